>>> design/dla_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dla_pkg: shared definitions for the lease allocator
// Table sizes, operation and status codes, register indexes, scan result and
// command structs, and the subnet membership check.
// ----------------------------------------------------------------------------
package dla_pkg;

  localparam int LEASE_ENTRIES = 64;
  localparam int RES_ENTRIES   = 16;
  localparam int LIDX_W        = $clog2(LEASE_ENTRIES);
  localparam int RIDX_W        = (RES_ENTRIES > 1) ? $clog2(RES_ENTRIES) : 1;
  localparam int HW_W          = 48;
  localparam int IP_W          = 32;
  localparam int T_W           = 32;
  localparam int POOL_STEPS    = LEASE_ENTRIES + RES_ENTRIES + 1;
  localparam int STEP_W        = $clog2(POOL_STEPS + 1);
  localparam int CFG_IDX_W     = 3;

  typedef enum logic [1:0] {
    OP_PROPOSE = 2'd0,
    OP_RESERVE = 2'd1,
    OP_RELEASE = 2'd2,
    OP_SLOT    = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_REFUSED   = 2'd1,
    ST_FULL      = 2'd2,
    ST_EXHAUSTED = 2'd3
  } status_e;

  localparam logic [CFG_IDX_W-1:0] CFG_NETWORK_BASE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PREFIX_LENGTH  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RANGE_FIRST    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_RANGE_LAST     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_LEASE_DURATION = 3'd4;

  typedef struct packed {
    logic [HW_W-1:0] hw;
    logic [IP_W-1:0] ip;
    logic [T_W-1:0]  start;
  } lease_ent_t;

  typedef struct packed {
    logic              clr_a;
    logic [LIDX_W-1:0] clr_a_idx;
    logic              clr_b;
    logic [LIDX_W-1:0] clr_b_idx;
    logic              we;
    logic [LIDX_W-1:0] w_idx;
    lease_ent_t        w_ent;
  } lease_cmd_t;

  typedef struct packed {
    logic              ip_hit;
    logic [LIDX_W-1:0] ip_idx;
    logic              ip_expired;
    logic              ip_hw_eq;
    logic              hw_hit;
    logic [LIDX_W-1:0] hw_idx;
    logic              hw_expired;
    logic [IP_W-1:0]   hw_ip;
    logic              free_hit;
    logic [LIDX_W-1:0] free_idx;
    logic              exp_hit;
    logic [LIDX_W-1:0] exp_idx;
    logic              any_hit;
    logic [LIDX_W-1:0] any_idx;
  } lease_res_t;

  typedef struct packed {
    logic            hw_hit;
    logic [IP_W-1:0] hw_ip;
    logic            ip_hit;
    logic [HW_W-1:0] ip_hw;
  } resv_res_t;

  function automatic logic ip_allowed(logic [IP_W-1:0] ip, logic [IP_W-1:0] net,
                                      logic [4:0] plen);
    logic [IP_W-1:0] mask;
    mask = (plen == 5'd0) ? '0 : (32'hFFFF_FFFF << (6'd32 - {1'b0, plen}));
    return ((ip & mask) == (net & mask)) && (ip != net) && (ip != (net | ~mask));
  endfunction

endpackage
`default_nettype wire

>>> design/dla_lease_table.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dla_lease_table: lease storage with a sequential match scan
// One memory read per cycle; the registered entry is compared against the
// keys and the first hit of each kind is kept.
// ----------------------------------------------------------------------------
module dla_lease_table (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         scan_start_i,
  input  wire logic [dla_pkg::IP_W-1:0]     key_ip_i,
  input  wire logic [dla_pkg::HW_W-1:0]     key_hw_i,
  input  wire logic                         ip_en_i,
  input  wire logic                         hw_en_i,
  input  wire logic [dla_pkg::T_W-1:0]      now_i,
  input  wire logic [dla_pkg::T_W-1:0]      duration_i,
  input  wire dla_pkg::lease_cmd_t          cmd_i,
  output logic                              done_o,
  output dla_pkg::lease_res_t               res_o
);

  dla_pkg::lease_ent_t mem [dla_pkg::LEASE_ENTRIES];
  dla_pkg::lease_ent_t rd_q;
  logic [dla_pkg::LEASE_ENTRIES-1:0] valid_q, valid_d;
  logic [dla_pkg::LIDX_W-1:0] cnt_q, rd_idx_q;
  logic busy_q, rd_vld_q, done_q;
  dla_pkg::lease_res_t res_q, res_d;
  logic v_c, exp_c, ip_m, hw_m;

  localparam logic [dla_pkg::LIDX_W-1:0] LastIdx =
    dla_pkg::LIDX_W'(dla_pkg::LEASE_ENTRIES - 1);

  always_ff @(posedge clk_i) begin
    if (cmd_i.we) begin
      mem[cmd_i.w_idx] <= cmd_i.w_ent;
    end
    if (busy_q) begin
      rd_q <= mem[cnt_q];
    end
  end

  always_comb begin
    valid_d = valid_q;
    if (cmd_i.clr_a) valid_d[cmd_i.clr_a_idx] = 1'b0;
    if (cmd_i.clr_b) valid_d[cmd_i.clr_b_idx] = 1'b0;
    if (cmd_i.we)    valid_d[cmd_i.w_idx]     = 1'b1;
  end

  assign v_c   = valid_q[rd_idx_q];
  assign exp_c = (now_i - rd_q.start) > duration_i;
  assign ip_m  = v_c && ip_en_i && (rd_q.ip == key_ip_i);
  assign hw_m  = v_c && hw_en_i && (rd_q.hw == key_hw_i);

  always_comb begin
    res_d = res_q;
    if (scan_start_i) begin
      res_d = '0;
    end else if (rd_vld_q) begin
      if (ip_m && !res_q.ip_hit) begin
        res_d.ip_hit     = 1'b1;
        res_d.ip_idx     = rd_idx_q;
        res_d.ip_expired = exp_c;
        res_d.ip_hw_eq   = (rd_q.hw == key_hw_i);
      end
      if (hw_m && !res_q.hw_hit) begin
        res_d.hw_hit     = 1'b1;
        res_d.hw_idx     = rd_idx_q;
        res_d.hw_expired = exp_c;
        res_d.hw_ip      = rd_q.ip;
      end
      if (!v_c && !res_q.free_hit) begin
        res_d.free_hit = 1'b1;
        res_d.free_idx = rd_idx_q;
      end
      if (exp_c && !res_q.exp_hit) begin
        res_d.exp_hit = 1'b1;
        res_d.exp_idx = rd_idx_q;
      end
      if ((ip_m || hw_m) && !res_q.any_hit) begin
        res_d.any_hit = 1'b1;
        res_d.any_idx = rd_idx_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      cnt_q    <= '0;
      busy_q   <= 1'b0;
      rd_vld_q <= 1'b0;
      rd_idx_q <= '0;
      done_q   <= 1'b0;
      res_q    <= '0;
    end else begin
      valid_q  <= valid_d;
      res_q    <= res_d;
      rd_vld_q <= busy_q;
      rd_idx_q <= cnt_q;
      done_q   <= rd_vld_q && (rd_idx_q == LastIdx);
      if (scan_start_i) begin
        cnt_q  <= '0;
        busy_q <= 1'b1;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == LastIdx) busy_q <= 1'b0;
      end
    end
  end

  assign done_o = done_q;
  assign res_o  = res_q;

endmodule
`default_nettype wire

>>> design/dla_resv_table.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dla_resv_table: static reservation slots with a sequential match scan
// One slot compared per cycle; the first hit by hardware address and by
// address is kept.
// ----------------------------------------------------------------------------
module dla_resv_table (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       wr_en_i,
  input  wire logic [dla_pkg::RIDX_W-1:0] wr_idx_i,
  input  wire logic                       wr_valid_i,
  input  wire logic [dla_pkg::HW_W-1:0]   wr_hw_i,
  input  wire logic [dla_pkg::IP_W-1:0]   wr_ip_i,
  input  wire logic                       scan_start_i,
  input  wire logic [dla_pkg::HW_W-1:0]   key_hw_i,
  input  wire logic [dla_pkg::IP_W-1:0]   key_ip_i,
  output logic                            done_o,
  output dla_pkg::resv_res_t              res_o
);

  logic [dla_pkg::RES_ENTRIES-1:0] valid_q;
  logic [dla_pkg::HW_W-1:0] hw_q [dla_pkg::RES_ENTRIES];
  logic [dla_pkg::IP_W-1:0] ip_q [dla_pkg::RES_ENTRIES];
  logic [dla_pkg::RIDX_W-1:0] cnt_q;
  logic busy_q, done_q, hm, im;
  dla_pkg::resv_res_t res_q, res_d;

  localparam logic [dla_pkg::RIDX_W-1:0] LastIdx =
    dla_pkg::RIDX_W'(dla_pkg::RES_ENTRIES - 1);

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      hw_q[wr_idx_i] <= wr_hw_i;
      ip_q[wr_idx_i] <= wr_ip_i;
    end
  end

  assign hm = valid_q[cnt_q] && (hw_q[cnt_q] == key_hw_i);
  assign im = valid_q[cnt_q] && (ip_q[cnt_q] == key_ip_i);

  always_comb begin
    res_d = res_q;
    if (scan_start_i) begin
      res_d = '0;
    end else if (busy_q) begin
      if (hm && !res_q.hw_hit) begin
        res_d.hw_hit = 1'b1;
        res_d.hw_ip  = ip_q[cnt_q];
      end
      if (im && !res_q.ip_hit) begin
        res_d.ip_hit = 1'b1;
        res_d.ip_hw  = hw_q[cnt_q];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      cnt_q   <= '0;
      busy_q  <= 1'b0;
      done_q  <= 1'b0;
      res_q   <= '0;
    end else begin
      res_q  <= res_d;
      done_q <= busy_q && (cnt_q == LastIdx);
      if (wr_en_i) valid_q[wr_idx_i] <= wr_valid_i;
      if (scan_start_i) begin
        cnt_q  <= '0;
        busy_q <= 1'b1;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == LastIdx) busy_q <= 1'b0;
      end
    end
  end

  assign done_o = done_q;
  assign res_o  = res_q;

endmodule
`default_nettype wire

>>> design/dhcp_lease_allocator_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dhcp_lease_allocator_core: lease table engine for one address pool
// Proposes, reserves and releases leases and writes reservation slots.
// ----------------------------------------------------------------------------
// Usage:
//  - Input channel (in_valid_i/in_ready_o) takes one request transaction;
//    in_ready_o is high only while the engine is idle.
//  - Output channel (out_valid_o/out_ready_i) returns one result transaction
//    per request. The result is held in registers until taken; a stalled
//    receiver simply holds the engine in its result state.
//  - Configuration channel (cfg_valid_i/cfg_ready_o) is always ready; write
//    only while no request is in flight. Unused indexes are ignored.
//  - Sequencing: a slot write needs no scan. A release runs one lease scan,
//    a reserve one reservation scan and up to two lease scans. A propose runs
//    two reservation scans and one lease scan and, when the pool must be
//    walked, a reservation scan per pool address tried, plus a lease scan when
//    no reservation blocks it (at most LEASE_ENTRIES + RES_ENTRIES + 1 addresses).
//    The lease memory scan reads one entry per cycle, the reservation scan one slot per cycle.
//  - Reset: all leases and reservations are invalid, registers take their
//    default subnet, pool and duration values. No clearing pass is needed.
// ----------------------------------------------------------------------------
module dhcp_lease_allocator_core (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  wire logic [dla_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  wire logic [31:0]                     cfg_data_i,
  input  wire logic                            in_valid_i,
  output logic                                 in_ready_o,
  input  wire logic [1:0]                      operation_i,
  input  wire logic [dla_pkg::HW_W-1:0]        hw_address_i,
  input  wire logic [dla_pkg::IP_W-1:0]        ip_address_i,
  input  wire logic [dla_pkg::T_W-1:0]         now_seconds_i,
  input  wire logic [3:0]                      slot_index_i,
  input  wire logic                            slot_enable_i,
  output logic                                 out_valid_o,
  input  wire logic                            out_ready_i,
  output logic [dla_pkg::IP_W-1:0]             result_address_o,
  output logic                                 granted_o,
  output logic [1:0]                           status_o
);

  // Sequencer states, one-hot.
  typedef enum logic [9:0] {
    S_IDLE = 10'b00_0000_0001,
    S_RA   = 10'b00_0000_0010,  // reservation scan by hardware address
    S_RB   = 10'b00_0000_0100,  // reservation scan by preferred address
    S_PL1  = 10'b00_0000_1000,  // lease scan for preferred address and client
    S_PR   = 10'b00_0001_0000,  // pool walk: reservation check of candidate
    S_PL   = 10'b00_0010_0000,  // pool walk: lease check of candidate
    S_RL1  = 10'b00_0100_0000,  // reserve: conflict check
    S_RL2  = 10'b00_1000_0000,  // reserve: pick entry and commit
    S_REL  = 10'b01_0000_0000,  // release lookup
    S_OUT  = 10'b10_0000_0000   // result held for the receiver
  } state_e;

  state_e state_q, state_d;
  logic   issued_q, issued_d;

  // Configuration registers.
  logic [31:0] net_q, first_q, last_q, dur_q;
  logic [4:0]  plen_q;

  // Request and working registers.
  dla_pkg::op_e              op_q, op_d;
  logic [dla_pkg::HW_W-1:0]  hw_q, hw_d;
  logic [dla_pkg::IP_W-1:0]  ip_q, ip_d;
  logic [dla_pkg::T_W-1:0]   now_q, now_d;
  logic [dla_pkg::IP_W-1:0]  pref_q, pref_d;
  logic                      from_cfg_q, from_cfg_d;
  logic [dla_pkg::IP_W-1:0]  cand_q, cand_d;
  logic [dla_pkg::STEP_W-1:0] n_q, n_d;
  logic [dla_pkg::IP_W-1:0]  key_ip_q, key_ip_d;
  logic                      ip_en_q, ip_en_d, hw_en_q, hw_en_d;

  // Result registers.
  logic [dla_pkg::IP_W-1:0]  addr_q, addr_d;
  dla_pkg::status_e          st_q, st_d;

  // Table interfaces.
  logic                 ls_start, ls_done, rs_start, rs_done;
  dla_pkg::lease_cmd_t  lcmd;
  dla_pkg::lease_res_t  lres;
  dla_pkg::resv_res_t   rres;
  logic                 slot_ok, rwr_en;

  logic [dla_pkg::IP_W-1:0] pref_v;
  logic drop_ip, hw_live;

  localparam logic [dla_pkg::STEP_W-1:0] LastStep =
    dla_pkg::STEP_W'(dla_pkg::POOL_STEPS - 1);

  // Configuration port: always ready.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      net_q   <= 32'd3232235776;
      plen_q  <= 5'd24;
      first_q <= 32'd3232235876;
      last_q  <= 32'd3232235976;
      dur_q   <= 32'd86400;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        dla_pkg::CFG_NETWORK_BASE:   net_q   <= cfg_data_i;
        dla_pkg::CFG_PREFIX_LENGTH:  plen_q  <= cfg_data_i[4:0];
        dla_pkg::CFG_RANGE_FIRST:    first_q <= cfg_data_i;
        dla_pkg::CFG_RANGE_LAST:     last_q  <= cfg_data_i;
        dla_pkg::CFG_LEASE_DURATION: dur_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Slot writes complete in the accept cycle.
  assign slot_ok = 32'(slot_index_i) < dla_pkg::RES_ENTRIES;
  assign rwr_en  = (state_q == S_IDLE) && in_valid_i &&
                   (dla_pkg::op_e'(operation_i) == dla_pkg::OP_SLOT) && slot_ok;

  dla_lease_table u_lease (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .scan_start_i (ls_start),
    .key_ip_i     (key_ip_q),
    .key_hw_i     (hw_q),
    .ip_en_i      (ip_en_q),
    .hw_en_i      (hw_en_q),
    .now_i        (now_q),
    .duration_i   (dur_q),
    .cmd_i        (lcmd),
    .done_o       (ls_done),
    .res_o        (lres)
  );

  dla_resv_table u_resv (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .wr_en_i      (rwr_en),
    .wr_idx_i     (dla_pkg::RIDX_W'(slot_index_i)),
    .wr_valid_i   (slot_enable_i),
    .wr_hw_i      (hw_address_i),
    .wr_ip_i      (ip_address_i),
    .scan_start_i (rs_start),
    .key_hw_i     (hw_q),
    .key_ip_i     (key_ip_q),
    .done_o       (rs_done),
    .res_o        (rres)
  );

  // Sequencer.
  always_comb begin
    state_d    = state_q;
    issued_d   = issued_q;
    op_d       = op_q;
    hw_d       = hw_q;
    ip_d       = ip_q;
    now_d      = now_q;
    pref_d     = pref_q;
    from_cfg_d = from_cfg_q;
    cand_d     = cand_q;
    n_d        = n_q;
    key_ip_d   = key_ip_q;
    ip_en_d    = ip_en_q;
    hw_en_d    = hw_en_q;
    addr_d     = addr_q;
    st_d       = st_q;
    lcmd       = '0;
    ls_start   = 1'b0;
    rs_start   = 1'b0;
    pref_v     = pref_q;
    drop_ip    = 1'b0;
    hw_live    = 1'b0;

    // Kick a scan once on entry to each scan state.
    if (!issued_q && (state_q == S_PL1 || state_q == S_PL || state_q == S_RL1 ||
                      state_q == S_RL2 || state_q == S_REL)) begin
      ls_start = 1'b1;
      issued_d = 1'b1;
    end
    if (!issued_q && (state_q == S_RA || state_q == S_RB || state_q == S_PR)) begin
      rs_start = 1'b1;
      issued_d = 1'b1;
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          op_d  = dla_pkg::op_e'(operation_i);
          hw_d  = hw_address_i;
          ip_d  = ip_address_i;
          now_d = now_seconds_i;
          unique case (dla_pkg::op_e'(operation_i))
            dla_pkg::OP_PROPOSE: begin
              // Drop a preferred address outside the pool.
              pref_d = (ip_address_i != '0 && (ip_address_i < first_q ||
                        ip_address_i > last_q)) ? '0 : ip_address_i;
              state_d = S_RA;
            end
            dla_pkg::OP_RESERVE: state_d = S_RA;
            dla_pkg::OP_RELEASE: begin
              key_ip_d = ip_address_i;
              ip_en_d  = 1'b1;
              hw_en_d  = 1'b0;
              state_d  = S_REL;
            end
            dla_pkg::OP_SLOT: begin
              addr_d  = ip_address_i;
              st_d    = slot_ok ? dla_pkg::ST_OK : dla_pkg::ST_REFUSED;
              state_d = S_OUT;
            end
            default: ;
          endcase
        end
      end

      S_RA: begin
        if (rs_done) begin
          issued_d = 1'b0;
          if (op_q == dla_pkg::OP_PROPOSE) begin
            // A static reservation overrides the preferred address.
            from_cfg_d = rres.hw_hit;
            pref_v     = rres.hw_hit ? rres.hw_ip : pref_q;
            pref_d     = pref_v;
            key_ip_d   = pref_v;
            state_d    = S_RB;
          end else begin
            key_ip_d = ip_q;
            ip_en_d  = 1'b1;
            hw_en_d  = 1'b1;
            if (!dla_pkg::ip_allowed(ip_q, net_q, plen_q)) begin
              addr_d  = '0;
              st_d    = dla_pkg::ST_REFUSED;
              state_d = S_OUT;
            end else if (rres.hw_hit && rres.hw_ip == ip_q) begin
              state_d = S_RL2;
            end else begin
              state_d = S_RL1;
            end
          end
        end
      end

      S_RB: begin
        if (rs_done) begin
          issued_d = 1'b0;
          // Refuse a preferred address outside the subnet or reserved for
          // another client.
          if (pref_q != '0 && (!dla_pkg::ip_allowed(pref_q, net_q, plen_q) ||
              (rres.ip_hit && rres.ip_hw != hw_q))) begin
            pref_v = '0;
          end
          pref_d   = pref_v;
          key_ip_d = pref_v;
          ip_en_d  = (pref_v != '0);
          hw_en_d  = !from_cfg_q;
          state_d  = S_PL1;
        end
      end

      S_PL1: begin
        if (ls_done) begin
          issued_d = 1'b0;
          // Purge an expired lease on the preferred address.
          drop_ip = lres.ip_hit && lres.ip_expired;
          if (drop_ip) begin
            lcmd.clr_a     = 1'b1;
            lcmd.clr_a_idx = lres.ip_idx;
          end
          hw_live = lres.hw_hit && !(drop_ip && lres.hw_idx == lres.ip_idx);
          if (hw_live && !lres.hw_expired) begin
            // Keep the client's own live lease.
            addr_d  = lres.hw_ip;
            st_d    = (lres.hw_ip != '0) ? dla_pkg::ST_OK : dla_pkg::ST_EXHAUSTED;
            state_d = S_OUT;
          end else begin
            if (hw_live) begin
              lcmd.clr_b     = 1'b1;
              lcmd.clr_b_idx = lres.hw_idx;
            end
            if (pref_q != '0 && (!lres.ip_hit || drop_ip)) begin
              addr_d  = pref_q;
              st_d    = dla_pkg::ST_OK;
              state_d = S_OUT;
            end else if (first_q > last_q) begin
              addr_d  = '0;
              st_d    = dla_pkg::ST_EXHAUSTED;
              state_d = S_OUT;
            end else begin
              cand_d   = first_q;
              n_d      = '0;
              key_ip_d = first_q;
              ip_en_d  = 1'b1;
              hw_en_d  = 1'b0;
              state_d  = S_PR;
            end
          end
        end
      end

      S_PR, S_PL: begin
        if ((state_q == S_PR && rs_done) || (state_q == S_PL && ls_done)) begin
          issued_d = 1'b0;
          if (state_q == S_PR && !rres.ip_hit) begin
            state_d = S_PL;
          end else if (state_q == S_PL && !(lres.ip_hit && !lres.ip_expired)) begin
            addr_d  = cand_q;
            st_d    = (cand_q != '0) ? dla_pkg::ST_OK : dla_pkg::ST_EXHAUSTED;
            state_d = S_OUT;
          end else if (cand_q == last_q || n_q == LastStep) begin
            // Candidate blocked and the walk is at its end.
            addr_d  = '0;
            st_d    = dla_pkg::ST_EXHAUSTED;
            state_d = S_OUT;
          end else begin
            // Advance to the next pool address.
            cand_d   = cand_q + 1'b1;
            key_ip_d = cand_q + 1'b1;
            n_d      = n_q + 1'b1;
            state_d  = S_PR;
          end
        end
      end

      S_RL1: begin
        if (ls_done) begin
          issued_d = 1'b0;
          if (lres.ip_hit && !lres.ip_expired && !lres.ip_hw_eq) begin
            addr_d  = '0;
            st_d    = dla_pkg::ST_REFUSED;
            state_d = S_OUT;
          end else begin
            // Drop the client's lease on another address.
            if (lres.hw_hit && lres.hw_ip != ip_q) begin
              lcmd.clr_b     = 1'b1;
              lcmd.clr_b_idx = lres.hw_idx;
            end
            state_d = S_RL2;
          end
        end
      end

      S_RL2: begin
        if (ls_done) begin
          issued_d = 1'b0;
          if (!lres.any_hit && !lres.free_hit && !lres.exp_hit) begin
            addr_d  = '0;
            st_d    = dla_pkg::ST_FULL;
            state_d = S_OUT;
          end else begin
            // Remove stale duplicates, then commit the new lease.
            lcmd.clr_a       = lres.ip_hit;
            lcmd.clr_a_idx   = lres.ip_idx;
            lcmd.clr_b       = lres.hw_hit;
            lcmd.clr_b_idx   = lres.hw_idx;
            lcmd.we          = 1'b1;
            lcmd.w_idx       = lres.any_hit  ? lres.any_idx :
                               lres.free_hit ? lres.free_idx : lres.exp_idx;
            lcmd.w_ent.hw    = hw_q;
            lcmd.w_ent.ip    = ip_q;
            lcmd.w_ent.start = now_q;
            addr_d           = ip_q;
            st_d             = dla_pkg::ST_OK;
            state_d          = S_OUT;
          end
        end
      end

      S_REL: begin
        if (ls_done) begin
          issued_d       = 1'b0;
          lcmd.clr_a     = lres.ip_hit;
          lcmd.clr_a_idx = lres.ip_idx;
          addr_d         = ip_q;
          st_d           = lres.ip_hit ? dla_pkg::ST_OK : dla_pkg::ST_REFUSED;
          state_d        = S_OUT;
        end
      end

      S_OUT: begin
        if (out_ready_i) state_d = S_IDLE;
      end

      default: state_d = S_IDLE;
    endcase
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      issued_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      issued_q <= issued_d;
    end
  end

  // Payload and working registers.
  always_ff @(posedge clk_i) begin
    op_q       <= op_d;
    hw_q       <= hw_d;
    ip_q       <= ip_d;
    now_q      <= now_d;
    pref_q     <= pref_d;
    from_cfg_q <= from_cfg_d;
    cand_q     <= cand_d;
    n_q        <= n_d;
    key_ip_q   <= key_ip_d;
    ip_en_q    <= ip_en_d;
    hw_en_q    <= hw_en_d;
    addr_q     <= addr_d;
    st_q       <= st_d;
  end

  assign in_ready_o       = (state_q == S_IDLE);
  assign out_valid_o      = (state_q == S_OUT);
  assign result_address_o = addr_q;
  assign granted_o        = (st_q == dla_pkg::ST_OK);
  assign status_o         = st_q;

endmodule
`default_nettype wire
